>>> rtl/itmr_pkg.sv
// ============================================================================
// itmr_pkg: shared types and constants for the interval timer
// Event codes, fixed stream field widths, parameter defaults and the
// command/status structs between controller and datapath.
// ============================================================================
package itmr_pkg;

    // Parameter defaults
    localparam int TIME_BITS_DEF     = 64;
    localparam int INTERVAL_BITS_DEF = 32;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths of the stream payload
    localparam int OP_W        = 3;
    localparam int REF_W       = 64;
    localparam int TIMEOUT_W   = 64;
    localparam int NOW_W       = 64;
    localparam int INTV_W      = 32;
    localparam int MEAN_W      = 40;
    localparam int COUNT_BITS  = 32;
    localparam int IN_DATA_W   = REF_W + TIMEOUT_W;
    localparam int OUT_FIELD_W = NOW_W + 1 + 4 * INTV_W + MEAN_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // Event codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_MEASURE = 3'd2;
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;     // capture the incoming transfer
        logic apply;        // carry out the event on the state
        logic div_start;    // launch the mean step division
        logic mean_update;  // fold the quotient into the mean
        logic out_load;     // load the result register
    } itmr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_measure;
        logic div_done;
    } itmr_status_t;

endpackage

>>> rtl/itmr_div.sv
// ============================================================================
// itmr_div: serial restoring divider
// Produces one quotient bit per cycle; a done pulse follows the last bit.
// ============================================================================
module itmr_div
    import itmr_pkg::*;
#(
    parameter int DIVIDEND_BITS = INTERVAL_BITS_DEF + FRACTION_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]    divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [DIVIDEND_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0]    rem_reg, rem_next;
    logic [COUNT_BITS-1:0]    dsr_reg, dsr_next;
    logic [COUNT_BITS:0]      trial;
    logic                     fits;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, acc_reg[DIVIDEND_BITS-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_BITS);
            acc_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            rem_next  = fits ? COUNT_BITS'(trial - {1'b0, dsr_reg}) : trial[COUNT_BITS-1:0];
            acc_next  = {acc_reg[DIVIDEND_BITS-2:0], fits};
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

>>> rtl/itmr_dp.sv
// ============================================================================
// itmr_dp: timer datapath
// Time count, start mark, interval statistics, mean step division and the
// result register.
// ============================================================================
module itmr_dp
    import itmr_pkg::*;
#(
    parameter int TIME_BITS     = TIME_BITS_DEF,
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  itmr_cmd_t             cmd,
    output itmr_status_t          status,
    input  logic [IN_DATA_W-1:0]  in_data,   // reference_time, timeout
    input  logic [OP_W-1:0]       in_op,     // op
    output logic [OUT_DATA_W-1:0] out_data   // now_time, expired, last, min, max, mean, count
);

    localparam int MEAN_BITS = INTERVAL_BITS + FRACTION_BITS;

    // Captured transfer
    logic [OP_W-1:0]      op_reg;
    logic [TIME_BITS-1:0] ref_reg;
    logic [TIMEOUT_W-1:0] tmo_reg;

    // Architectural state
    logic [TIME_BITS-1:0]     time_reg, time_next;
    logic [TIME_BITS-1:0]     mark_reg, mark_next;
    logic [INTERVAL_BITS-1:0] recent_reg, recent_next;
    logic [INTERVAL_BITS-1:0] low_reg, low_next;
    logic [INTERVAL_BITS-1:0] high_reg, high_next;
    logic [MEAN_BITS-1:0]     mean_reg, mean_next;
    logic [COUNT_BITS-1:0]    samples_reg, samples_next;
    logic                     dir_reg, dir_next;

    // Result register
    logic [NOW_W-1:0]  out_now_reg;
    logic              out_exp_reg;
    logic [INTV_W-1:0] out_last_reg;
    logic [INTV_W-1:0] out_min_reg;
    logic [INTV_W-1:0] out_max_reg;
    logic [MEAN_W-1:0] out_mean_reg;
    logic [INTV_W-1:0] out_count_reg;

    logic [TIME_BITS-1:0]     span;
    logic [63:0]              span_wide;
    logic [INTERVAL_BITS-1:0] interval;
    logic [COUNT_BITS-1:0]    samples_inc;
    logic [MEAN_BITS-1:0]     scaled;
    logic                     scaled_ge;
    logic [MEAN_BITS-1:0]     div_dividend;
    logic [MEAN_BITS-1:0]     quotient;
    logic                     div_done;
    logic [TIME_BITS-1:0]     elapsed;
    logic                     expired;
    logic [63:0]              mean_wide;

    // Capture the accepted transfer
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= in_op;
            ref_reg <= in_data[TIME_BITS-1:0];
            tmo_reg <= in_data[REF_W +: TIMEOUT_W];
        end
    end

    // Measured span, saturated to the interval width
    assign span        = time_reg - mark_reg;
    assign span_wide   = 64'(span);
    assign interval    = (|span_wide[63:INTERVAL_BITS]) ? '1 : span_wide[INTERVAL_BITS-1:0];
    assign samples_inc = (samples_reg != '1) ? samples_reg + COUNT_BITS'(1) : samples_reg;

    // Mean step: magnitude of scaled interval minus mean
    assign scaled       = MEAN_BITS'(interval) << FRACTION_BITS;
    assign scaled_ge    = (scaled >= mean_reg);
    assign div_dividend = scaled_ge ? scaled - mean_reg : mean_reg - scaled;

    // Elapsed check against the full-width timeout
    assign elapsed = time_reg - ref_reg;
    assign expired = cmd.apply && (op_reg == OP_CHECK) && (64'(elapsed) > tmo_reg);

    itmr_div #(
        .DIVIDEND_BITS (MEAN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (samples_inc),
        .done     (div_done),
        .quotient (quotient)
    );

    // Next state of the timer and statistics
    always_comb
    begin
        time_next    = time_reg;
        mark_next    = mark_reg;
        recent_next  = recent_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        mean_next    = mean_reg;
        samples_next = samples_reg;
        dir_next     = dir_reg;
        if (cmd.apply)
        begin
            case (op_reg)
                OP_TICK:
                begin
                    time_next = time_reg + TIME_BITS'(1);
                end
                OP_START:
                begin
                    mark_next = time_reg;
                end
                OP_MEASURE:
                begin
                    mark_next    = time_reg;
                    recent_next  = interval;
                    samples_next = samples_inc;
                    if (interval < low_reg)
                    begin
                        low_next = interval;
                    end
                    if (interval > high_reg)
                    begin
                        high_next = interval;
                    end
                end
                OP_CLEAR:
                begin
                    mark_next    = '0;
                    recent_next  = '0;
                    low_next     = '1;
                    high_next    = '0;
                    mean_next    = '0;
                    samples_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.div_start)
        begin
            dir_next = scaled_ge;
        end
        if (cmd.mean_update)
        begin
            mean_next = dir_reg ? mean_reg + quotient : mean_reg - quotient;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= '0;
            mark_reg    <= '0;
            recent_reg  <= '0;
            low_reg     <= '1;
            high_reg    <= '0;
            mean_reg    <= '0;
            samples_reg <= '0;
            dir_reg     <= 1'b0;
        end
        else
        begin
            time_reg    <= time_next;
            mark_reg    <= mark_next;
            recent_reg  <= recent_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            mean_reg    <= mean_next;
            samples_reg <= samples_next;
            dir_reg     <= dir_next;
        end
    end

    // Load the result from the updated state
    assign mean_wide = 64'(mean_next);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_now_reg   <= NOW_W'(time_next);
            out_exp_reg   <= expired;
            out_last_reg  <= INTV_W'(recent_next);
            out_min_reg   <= INTV_W'(low_next);
            out_max_reg   <= INTV_W'(high_next);
            out_mean_reg  <= mean_wide[MEAN_W-1:0];
            out_count_reg <= samples_next;
        end
    end

    assign out_data = {(OUT_DATA_W - OUT_FIELD_W)'(0), out_count_reg, out_mean_reg,
                       out_max_reg, out_min_reg, out_last_reg, out_exp_reg, out_now_reg};

    assign status.is_measure = (op_reg == OP_MEASURE);
    assign status.div_done   = div_done;

endmodule

>>> rtl/itmr_ctrl.sv
// ============================================================================
// itmr_ctrl: timer controller
// Sequences capture, execution, the mean division and the result handoff.
// ============================================================================
module itmr_ctrl
    import itmr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  itmr_status_t status,
    output itmr_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || out_ready;

    // Sequence one item at a time
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_measure)
                begin
                    cmd.apply     = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else if (out_free)
                begin
                    cmd.apply    = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.mean_update = 1'b1;
                    cmd.out_load    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the downstream transfer completes
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;

endmodule

>>> rtl/interval_timer_with_statistics.sv
// Sequence: tick, start, check, clear and unused codes are captured, applied and
//   loaded into the result register; a measure also runs the serial mean divider
//   (one quotient bit per cycle) first. One item is taken at a time: s_axis_tready
//   is low until the result is loaded, and a stalled output holds back the load.
// Reset: rst_n clears time, mark and statistics (minimum to all ones) and
//   drops m_axis_tvalid at once.
// ============================================================================
// interval_timer_with_statistics: tick-driven timer with interval statistics
// Stream in events, stream out the time count and statistics after each one.
// ============================================================================
module interval_timer_with_statistics
    import itmr_pkg::*;
#(
    parameter int TIME_BITS     = TIME_BITS_DEF,
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // reference_time[63:0], timeout[127:64]
    input  logic [OP_W-1:0]       s_axis_tuser,   // op[2:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // now_time[63:0], expired[64], last_interval[96:65], min_interval[128:97],
    // max_interval[160:129], mean_interval[200:161], sample_count[232:201], zeros
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    itmr_cmd_t    cmd;
    itmr_status_t status;

    itmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    itmr_dp #(
        .TIME_BITS     (TIME_BITS),
        .INTERVAL_BITS (INTERVAL_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_axis_tdata),
        .in_op    (s_axis_tuser),
        .out_data (m_axis_tdata)
    );

endmodule

>>> rtl/itmr_chk.sv
// ============================================================================
// itmr_chk: port-level checker for the interval timer
// Watches the stream ports and flags handshake and statistics slips.
// ============================================================================
module itmr_chk
    import itmr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata    // now, expired, last, min, max, mean, count
);

    logic [INTV_W-1:0] min_f;
    logic [INTV_W-1:0] max_f;
    logic [MEAN_W-1:0] mean_f;
    logic [INTV_W-1:0] count_f;

    assign min_f   = m_axis_tdata[128:97];
    assign max_f   = m_axis_tdata[160:129];
    assign mean_f  = m_axis_tdata[200:161];
    assign count_f = m_axis_tdata[232:201];

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Only one item is in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer taken while an item is in work");

    // With samples present, the minimum never exceeds the maximum
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (count_f != '0) |-> (min_f <= max_f))
        else $error("minimum above maximum");

    // With no samples, maximum and mean are zero
    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (count_f == '0) |-> (max_f == '0) && (mean_f == '0))
        else $error("statistics not empty without samples");

endmodule

bind interval_timer_with_statistics itmr_chk u_itmr_chk (.*);
